@@ hw/rtl/asrt_pkg.sv @@
// Shared types and constants of the aging route table.
`default_nettype none
package asrt_pkg;
	localparam logic [2:0] ACT_TICK   = 3'd0;
	localparam logic [2:0] ACT_ADD    = 3'd1;
	localparam logic [2:0] ACT_LOOKUP = 3'd2;
	localparam logic [2:0] ACT_BEST   = 3'd3;
	localparam logic [2:0] ACT_COUNT  = 3'd4;
	localparam logic [2:0] ACT_GET    = 3'd5;
	localparam logic [7:0] COST_NEVER = 8'd255;
	localparam logic [7:0] AGE_MAX    = 8'd255;
	localparam logic [7:0] LIFE_RESET = 8'd60;
	localparam logic [7:0] KEEP_RESET = 8'd10;
	localparam logic       REG_LIFE   = 1'b0;
	localparam logic       REG_KEEP   = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_APPLY, ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;   // capture the input beat
		logic clr;    // restart the scan index
		logic step;   // examine one slot
		logic apply;  // update the table and form the result
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_end;
	} sts_t;
endpackage
`default_nettype wire

@@ hw/rtl/aging_sink_route_table.sv @@
// Top level of the aging route table.
// Each beat is handled alone: a scan examines one slot per cycle over the live entries,
// then an update step, which waits until the output register has room, writes the
// result to the output register. A new beat is accepted once the previous result has
// been registered, even while it still waits to be taken.
`default_nettype none
module aging_sink_route_table
	import asrt_pkg::*;
#(
	parameter int ENTRIES = 8,
	parameter int ADDR_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // action[2:0], route_addr[18:3], route_cost[26:19], position[34:27]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata   // hit[0], entry_addr[16:1], entry_cost[24:17], entry_age[32:25], entry_count[36:33]
);
	cmd_t cmd;
	sts_t sts;
	logic busy, done;
	logic hit;
	logic [15:0] ra;
	logic [7:0] rc, rg;
	logic [3:0] rn;

	assign s_tready = !busy;
	wire out_room = !m_tvalid || m_tready;

	asrt_ctrl u_ctrl (.clk, .arst_n, .in_fire(s_tvalid && s_tready), .out_room,
		.sts, .cmd, .busy, .done);

	asrt_dp #(.ENTRIES(ENTRIES), .ADDR_BITS(ADDR_BITS)) u_dp (.clk, .arst_n, .cmd, .sts,
		.cfg_we, .cfg_idx(cfg_index), .cfg_data,
		.in_action(s_tdata[2:0]), .in_addr(s_tdata[18:3]), .in_cost(s_tdata[26:19]),
		.in_pos(s_tdata[34:27]),
		.res_hit(hit), .res_addr(ra), .res_cost(rc), .res_age(rg), .res_count(rn));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)       m_tvalid <= 1'b0;
		else if (done)     m_tvalid <= 1'b1;
		else if (m_tready) m_tvalid <= 1'b0;
	end

	assign m_tdata = {3'b000, rn, rg, rc, ra, hit};
endmodule
`default_nettype wire

@@ hw/rtl/asrt_ctrl.sv @@
// Controller state machine of the aging route table.
`default_nettype none
module asrt_ctrl
	import asrt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_fire,
	input  wire logic out_room,
	input  sts_t      sts,
	output cmd_t      cmd,
	output logic      busy,
	output logic      done
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_fire) state_d = ST_SCAN;
			ST_SCAN:  if (sts.scan_end) state_d = ST_APPLY;
			ST_APPLY: if (out_room) state_d = ST_DONE;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				cmd.load = in_fire;
				cmd.clr = in_fire;
			end
			ST_SCAN:  cmd.step = !sts.scan_end;
			ST_APPLY: begin
				cmd.apply = out_room;
				done = out_room;
			end
			ST_DONE:  ;
			default:  ;
		endcase
	end
endmodule
`default_nettype wire

@@ hw/rtl/asrt_dp.sv @@
// Datapath of the aging route table: slot registers, scan unit and update.
`default_nettype none
module asrt_dp
	import asrt_pkg::*;
#(
	parameter int ENTRIES = 8,
	parameter int ADDR_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  cmd_t                      cmd,
	output sts_t                      sts,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_idx,
	input  wire logic [7:0]           cfg_data,
	input  wire logic [2:0]           in_action,
	input  wire logic [15:0]          in_addr,
	input  wire logic [7:0]           in_cost,
	input  wire logic [7:0]           in_pos,
	output logic                      res_hit,
	output logic [15:0]               res_addr,
	output logic [7:0]                res_cost,
	output logic [7:0]                res_age,
	output logic [3:0]                res_count
);
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int AW = (ADDR_BITS < 16) ? ADDR_BITS : 16;

	logic [AW-1:0] addr_q [ENTRIES];
	logic [7:0]    cost_q [ENTRIES];
	logic [7:0]    age_q  [ENTRIES];
	logic [CW-1:0] cnt_q;
	logic [7:0]    life_q, keep_q;

	logic [2:0]    act_q;
	logic [AW-1:0] a_q;
	logic [7:0]    c_q, p_q;
	logic [CW-1:0] i_q;
	logic [7:0]    low_q, oage_q;
	logic          bf_q;
	logic [IW-1:0] best_q, old_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			life_q <= LIFE_RESET;
			keep_q <= KEEP_RESET;
		end else if (cfg_we) begin
			if (cfg_idx == REG_LIFE) life_q <= cfg_data;
			else                     keep_q <= cfg_data;
		end
	end

	assign sts.scan_end = (i_q >= cnt_q);

	wire [IW-1:0] ii = i_q[IW-1:0];
	wire match = (act_q != ACT_BEST) ? (addr_q[ii] == a_q) : 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= in_action;
			a_q <= in_addr[AW-1:0];
			c_q <= in_cost;
			p_q <= in_pos;
		end
		if (cmd.clr) begin
			i_q <= '0;
			low_q <= COST_NEVER;
			bf_q <= 1'b0;
			best_q <= '0;
			old_q <= '0;
			oage_q <= '0;
		end else if (cmd.step) begin
			i_q <= i_q + 1'b1;
			if (match && cost_q[ii] < low_q) begin
				low_q <= cost_q[ii];
				bf_q <= 1'b1;
				best_q <= ii;
			end
			if (age_q[ii] >= oage_q) begin
				oage_q <= age_q[ii];
				old_q <= ii;
			end
		end
	end

	// Tick survivors: compact the list keeping order.
	logic [7:0]    tage [ENTRIES];
	logic          keep_e [ENTRIES];
	logic [IW-1:0] dst [ENTRIES];
	logic [CW-1:0] nsurv;
	always_comb begin
		nsurv = '0;
		for (int k = 0; k < ENTRIES; k++) begin
			tage[k] = (age_q[k] < AGE_MAX) ? age_q[k] + 8'd1 : age_q[k];
			keep_e[k] = (CW'(k) < cnt_q) && (tage[k] < life_q);
			dst[k] = nsurv[IW-1:0];
			if (keep_e[k]) nsurv = nsurv + 1'b1;
		end
	end

	// Add: remove one index on a hit or, when full, by eviction, then push to front.
	wire          full = (cnt_q >= CW'(ENTRIES));
	wire          rm = bf_q || full;
	wire [IW-1:0] rmi = bf_q ? best_q : old_q;
	wire [7:0]    ncost = (bf_q && cost_q[best_q] < c_q && age_q[best_q] < keep_q)
	                      ? cost_q[best_q] : c_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (cmd.apply) begin
			if (act_q == ACT_TICK) cnt_q <= nsurv;
			else if (act_q == ACT_ADD) cnt_q <= rm ? cnt_q : cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply && act_q == ACT_TICK) begin
			for (int k = 0; k < ENTRIES; k++)
				if (keep_e[k]) begin
					addr_q[dst[k]] <= addr_q[k];
					cost_q[dst[k]] <= cost_q[k];
					age_q[dst[k]] <= tage[k];
				end
		end else if (cmd.apply && act_q == ACT_ADD) begin
			for (int k = 1; k < ENTRIES; k++)
				if (!rm || IW'(k) <= rmi) begin
					addr_q[k] <= addr_q[k-1];
					cost_q[k] <= cost_q[k-1];
					age_q[k] <= age_q[k-1];
				end
			addr_q[0] <= a_q;
			cost_q[0] <= ncost;
			age_q[0] <= '0;
		end
	end

	logic        hit_d;
	logic [15:0] addr_d;
	logic [7:0]  cost_d, age_d;
	logic [3:0]  count_d;
	always_comb begin
		hit_d = 1'b0;
		addr_d = '0;
		cost_d = '0;
		age_d = '0;
		count_d = 4'(cnt_q);
		case (act_q)
			ACT_TICK: count_d = 4'(nsurv);
			ACT_ADD: begin
				hit_d = bf_q;
				addr_d = 16'(a_q);
				cost_d = ncost;
				count_d = 4'(rm ? cnt_q : cnt_q + 1'b1);
			end
			ACT_LOOKUP, ACT_BEST: begin
				if (bf_q) begin
					hit_d = 1'b1;
					addr_d = 16'(addr_q[best_q]);
					cost_d = cost_q[best_q];
					age_d = age_q[best_q];
				end
			end
			ACT_GET: begin
				if (9'(p_q) < 9'(cnt_q)) begin
					hit_d = 1'b1;
					addr_d = 16'(addr_q[p_q[IW-1:0]]);
					cost_d = cost_q[p_q[IW-1:0]];
					age_d = age_q[p_q[IW-1:0]];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			res_hit <= hit_d;
			res_addr <= addr_d;
			res_cost <= cost_d;
			res_age <= age_d;
			res_count <= count_d;
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/asrt_checker.sv @@
// Port-level checker of the aging route table, bound to the top level.
`default_nettype none
module asrt_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready) else $error("second beat taken");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[36:33] <= 4'd8) else $error("count too big");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:37] == 3'd0) else $error("pad bits set");
endmodule

bind aging_sink_route_table asrt_checker u_chk (.clk, .arst_n, .s_tvalid, .s_tready,
	.m_tvalid, .m_tready, .m_tdata);
`default_nettype wire

@@ verif/tb_aging_sink_route_table.sv @@
// Self-checking testbench for the aging route table: stream stimulus, table predictor, result check.
`timescale 1ns / 1ps
module tb_aging_sink_route_table;
	import asrt_pkg::*;

	localparam int SLOTS = 8;
	localparam int LIMIT_CYCLES = 400000;

	// Packed from the top bit down, so that bit 0 is hit as on m_tdata.
	typedef struct packed {
		logic [3:0] count;
		logic [7:0] age;
		logic [7:0] cost;
		logic [15:0] addr;
		logic       hit;
	} route_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [7:0] cfg_data;
	logic s_tvalid;
	logic s_tready;
	logic [39:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [39:0] m_tdata;

	aging_sink_route_table dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// Predicted table state.
	logic [7:0] life_reg;
	logic [7:0] keep_reg;
	int unsigned tbl_n;
	logic [15:0] tbl_addr [SLOTS];
	logic [7:0] tbl_cost [SLOTS];
	logic [7:0] tbl_age [SLOTS];

	route_result_t pending_results [$];
	int unsigned mismatches;
	longint unsigned cycles;
	bit quiet;          // no idling on either side
	int unsigned addr_span;  // random addresses are drawn from a narrow span so re-adds happen

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb_aging_sink_route_table: FAIL");
			$finish;
		end
	end

	function automatic int find_lowest(bit by_addr, logic [15:0] a);
		logic [7:0] lowest;
		int best;
		lowest = COST_NEVER;
		best = -1;
		for (int i = 0; i < tbl_n; i++) begin
			if (by_addr && tbl_addr[i] != a)
				continue;
			if (tbl_cost[i] < lowest) begin
				lowest = tbl_cost[i];
				best = i;
			end
		end
		return best;
	endfunction

	task automatic remove_slot(int idx);
		for (int i = idx; i + 1 < tbl_n; i++) begin
			tbl_addr[i] = tbl_addr[i + 1];
			tbl_cost[i] = tbl_cost[i + 1];
			tbl_age[i] = tbl_age[i + 1];
		end
		if (tbl_n > 0)
			tbl_n--;
	endtask

	task automatic predict_route(logic [2:0] act, logic [15:0] a, logic [7:0] c,
			logic [7:0] pos);
		route_result_t r;
		int idx;
		int i;
		int oldest;
		r = '0;
		case (act)
			ACT_TICK: begin
				i = 0;
				while (i < tbl_n) begin
					if (tbl_age[i] < AGE_MAX)
						tbl_age[i]++;
					if (tbl_age[i] >= life_reg)
						remove_slot(i);
					else
						i++;
				end
			end
			ACT_ADD: begin
				idx = find_lowest(1'b1, a);
				if (idx >= 0) begin
					if (tbl_cost[idx] < c && tbl_age[idx] < keep_reg)
						c = tbl_cost[idx];
					remove_slot(idx);
					r.hit = 1'b1;
				end else if (tbl_n >= SLOTS) begin
					oldest = 0;
					for (int k = 0; k < tbl_n; k++)
						if (tbl_age[k] >= tbl_age[oldest])
							oldest = k;
					remove_slot(oldest);
				end
				for (int k = tbl_n; k > 0; k--) begin
					tbl_addr[k] = tbl_addr[k - 1];
					tbl_cost[k] = tbl_cost[k - 1];
					tbl_age[k] = tbl_age[k - 1];
				end
				tbl_addr[0] = a;
				tbl_cost[0] = c;
				tbl_age[0] = 8'd0;
				tbl_n++;
				r.addr = a;
				r.cost = c;
			end
			ACT_LOOKUP, ACT_BEST: begin
				idx = find_lowest(act == ACT_LOOKUP, a);
				if (idx >= 0) begin
					r.hit = 1'b1;
					r.addr = tbl_addr[idx];
					r.cost = tbl_cost[idx];
					r.age = tbl_age[idx];
				end
			end
			ACT_GET: begin
				if (pos < tbl_n) begin
					r.hit = 1'b1;
					r.addr = tbl_addr[pos];
					r.cost = tbl_cost[pos];
					r.age = tbl_age[pos];
				end
			end
			default: ;
		endcase
		r.count = tbl_n[3:0];
		pending_results.push_back(r);
	endtask

	// Sends one beat; the prediction is made at the accepting edge. Valid drops only
	// while idling, so a beat can follow the previous one with no gap.
	task automatic send_route(logic [2:0] act, logic [15:0] a, logic [7:0] c, logic [7:0] pos);
		while (!quiet && $urandom_range(99) < 28) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, pos, c, a, act};
		do
			@(posedge clk);
		while (!s_tready);
		predict_route(act, a, c, pos);
	endtask

	task automatic send_random;
		logic [2:0] act;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 35)
			act = ACT_ADD;
		else if (pick < 55)
			act = ACT_TICK;
		else if (pick < 70)
			act = ACT_LOOKUP;
		else if (pick < 80)
			act = ACT_BEST;
		else if (pick < 90)
			act = ACT_GET;
		else
			act = 3'($urandom_range(7, 4));
		send_route(act,
			($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(addr_span)),
			($urandom_range(15) == 0) ? COST_NEVER : 8'($urandom),
			($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(9)));
	endtask

	task automatic wait_drained;
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [7:0] val);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_LIFE)
			life_reg = val;
		else
			keep_reg = val;
	endtask

	// Result checker.
	always @(posedge clk) begin
		route_result_t got;
		route_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[36:0];
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat %h", m_tdata);
			end else begin
				want = pending_results.pop_front();
				if (got !== want || m_tdata[39:37] !== 3'd0) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: expected hit=%0d addr=%h cost=%0d age=%0d ",
							"cnt=%0d, got hit=%0d addr=%h cost=%0d age=%0d cnt=%0d"},
							want.hit, want.addr, want.cost, want.age, want.count,
							got.hit, got.addr, got.cost, got.age, got.count);
				end
			end
		end
		m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 28);
	end

	task automatic test_directed;
		send_route(ACT_COUNT, 16'h0000, 8'h00, 8'h00);
		send_route(ACT_BEST, 16'h0000, 8'h00, 8'h00);
		send_route(ACT_GET, 16'h0000, 8'h00, 8'h00);
		send_route(ACT_TICK, 16'h0000, 8'h00, 8'h00);
		send_route(ACT_ADD, 16'hFFFF, 8'hFF, 8'hFF);
		send_route(ACT_ADD, 16'hFFFF, 8'd3, 8'h00);
		send_route(ACT_LOOKUP, 16'hFFFF, 8'h00, 8'h00);
		send_route(ACT_ADD, 16'h0000, 8'd0, 8'h00);
		send_route(ACT_ADD, 16'hFFFF, 8'd9, 8'h00);
		send_route(ACT_TICK, 16'h0000, 8'h00, 8'h00);
		send_route(ACT_ADD, 16'h1234, 8'd7, 8'h00);
		for (int i = 0; i < 7; i++)
			send_route(ACT_ADD, 16'(16'h0100 + i), 8'(20 + i), 8'h00);
		send_route(ACT_GET, 16'h0000, 8'h00, 8'd7);
		send_route(ACT_GET, 16'h0000, 8'h00, 8'hFF);
		send_route(ACT_BEST, 16'h0000, 8'h00, 8'h00);
		send_route(3'd6, 16'hAAAA, 8'h55, 8'hAA);
		send_route(3'd7, 16'h5555, 8'hAA, 8'h55);
		send_route(ACT_LOOKUP, 16'hBEEF, 8'h00, 8'h00);
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++)
			send_random();
	endtask

	task automatic test_settings;
		write_reg(REG_LIFE, 8'd1);
		write_reg(REG_KEEP, 8'd0);
		test_random(80);
		write_reg(REG_LIFE, 8'd255);
		write_reg(REG_KEEP, 8'd255);
		addr_span = 12;
		test_random(250);
		write_reg(REG_LIFE, 8'd5);
		write_reg(REG_KEEP, 8'd3);
		test_random(150);
		write_reg(REG_LIFE, 8'd0);
		test_random(40);
		write_reg(REG_LIFE, 8'd20);
		write_reg(REG_KEEP, 8'd6);
		addr_span = 200;
		test_random(100);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = 8'd0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cycles = 0;
		mismatches = 0;
		quiet = 1'b0;
		addr_span = 20;
		life_reg = LIFE_RESET;
		keep_reg = KEEP_RESET;
		tbl_n = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(200);
		// Stretch with no idling on either side.
		quiet = 1'b1;
		test_random(100);
		quiet = 1'b0;
		wait_drained();
		test_settings();

		wait_drained();
		if (mismatches == 0)
			$display("tb_aging_sink_route_table: PASS");
		else
			$display("tb_aging_sink_route_table: FAIL");
		$finish;
	end
endmodule

@@ files.f @@
hw/rtl/asrt_pkg.sv
hw/rtl/asrt_ctrl.sv
hw/rtl/asrt_dp.sv
hw/rtl/aging_sink_route_table.sv
hw/rtl/asrt_checker.sv
verif/tb_aging_sink_route_table.sv
